[sv/ultrasonic_echo_ranger_defines.svh]
// Assertion macros shared by the ultrasonic echo ranger RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// same-cycle implication, held off during reset
`define URE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define URE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ure_pkg.sv]
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; used by every module of the block.
package ure_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS
    } t_phase;

    // register index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_TRIGGER    = 3'd0,
        REG_TIMEOUT    = 3'd1,
        REG_RANGE_LOW  = 3'd2,
        REG_RANGE_HIGH = 3'd3,
        REG_SCALE      = 3'd4
    } t_reg_idx;

    localparam int TRIG_W     = 10;
    localparam int PULSE_W    = 16;
    localparam int SCALE_W    = 8;
    localparam int DIST_W     = 18;
    localparam int PROD_W     = PULSE_W + SCALE_W;
    localparam int RECIP_W    = 25;
    localparam int RECIP_SHIFT = 31;
    localparam int MUL_W      = PROD_W + RECIP_W;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int ADDR_W     = 5;
    localparam int APB_W      = 32;

    // ceil(2^31 / 100): exact quotient for every 24-bit dividend
    localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;

    localparam logic [TRIG_W-1:0]  TRIGGER_RST    = 10'd10;
    localparam logic [PULSE_W-1:0] TIMEOUT_RST    = 16'd32768;
    localparam logic [PULSE_W-1:0] RANGE_LOW_RST  = 16'd1000;
    localparam logic [PULSE_W-1:0] RANGE_HIGH_RST = 16'd5000;
    localparam logic [SCALE_W-1:0] SCALE_RST      = 8'd17;

    typedef struct packed {
        logic [TRIG_W-1:0]  trigger_ticks;
        logic [PULSE_W-1:0] timeout_ticks;
        logic [PULSE_W-1:0] range_low;
        logic [PULSE_W-1:0] range_high;
        logic [SCALE_W-1:0] scale_mult;
    } t_cfg;

    // per-tick result of the phase sequencer, before distance and range
    typedef struct packed {
        logic               trigger;
        logic               busy;
        logic               done;
        logic               timed_out;
        logic [PULSE_W-1:0] pulse;
    } t_raw;

endpackage

[sv/ure_front.sv]
// Phase sequencer: takes one tick per transfer and produces the raw result.
// Depends on ure_pkg.
module ure_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_start,
    input  logic            i_echo,
    input  ure_pkg::t_cfg   i_cfg,
    input  logic            i_full,
    output logic            o_push,
    output ure_pkg::t_raw   o_raw
);

    localparam int CW = (COUNT_WIDTH > ure_pkg::PULSE_W) ? COUNT_WIDTH : ure_pkg::PULSE_W;

    ure_pkg::t_phase        r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_pc, n_pc;
    logic [COUNT_WIDTH-1:0] r_since, n_since;
    logic                   r_echo_prev;

    logic                   accept;
    logic                   rise, fall;
    logic [COUNT_WIDTH-1:0] pc_inc, since_inc;
    logic [CW-1:0]          tlen, pc_wide;
    logic                   trig_end, tout_hit, start_short;
    logic [ure_pkg::PULSE_W-1:0] pulse_sat;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    assign rise = i_echo && !r_echo_prev;
    assign fall = !i_echo && r_echo_prev;

    assign pc_inc    = (r_pc == '1) ? r_pc : r_pc + COUNT_WIDTH'(1);
    assign since_inc = (r_since == '1) ? r_since : r_since + COUNT_WIDTH'(1);

    // zero trigger length acts as one
    assign tlen = (i_cfg.trigger_ticks == '0) ? CW'(1) : CW'(i_cfg.trigger_ticks);
    assign start_short = (tlen == CW'(1));
    assign trig_end = (CW'(pc_inc) >= tlen) || (pc_inc == '1);
    assign tout_hit = (CW'(since_inc) >= CW'(i_cfg.timeout_ticks)) || (since_inc == '1);

    assign pc_wide   = CW'(r_pc);
    assign pulse_sat = (pc_wide > CW'({ure_pkg::PULSE_W{1'b1}})) ?
                       {ure_pkg::PULSE_W{1'b1}} : pc_wide[ure_pkg::PULSE_W-1:0];

    // next state
    always_comb begin
        n_phase = r_phase;
        n_pc    = r_pc;
        n_since = r_since;
        case (r_phase)
            ure_pkg::PH_IDLE: begin
                if (i_start) begin
                    n_pc    = COUNT_WIDTH'(1);
                    n_since = '0;
                    n_phase = start_short ? ure_pkg::PH_WAIT : ure_pkg::PH_TRIG;
                end
            end
            ure_pkg::PH_TRIG: begin
                n_pc = pc_inc;
                if (trig_end) begin
                    n_phase = ure_pkg::PH_WAIT;
                    n_since = '0;
                end
            end
            ure_pkg::PH_WAIT, ure_pkg::PH_MEAS: begin
                n_since = since_inc;
                if ((r_phase == ure_pkg::PH_MEAS) && fall) begin
                    n_phase = ure_pkg::PH_IDLE;
                    n_pc    = '0;
                end else if (tout_hit) begin
                    n_phase = ure_pkg::PH_IDLE;
                    n_pc    = '0;
                end else if (r_phase == ure_pkg::PH_WAIT) begin
                    if (rise) begin
                        n_phase = ure_pkg::PH_MEAS;
                        n_pc    = COUNT_WIDTH'(1);
                    end
                end else begin
                    n_pc = pc_inc;
                end
            end
            default: begin
                n_phase = ure_pkg::PH_IDLE;
            end
        endcase
    end

    // outputs; a falling edge wins over the timeout
    always_comb begin
        o_raw = '0;
        case (r_phase)
            ure_pkg::PH_IDLE: begin
                o_raw.trigger = i_start;
            end
            ure_pkg::PH_TRIG: begin
                o_raw.trigger = 1'b1;
            end
            ure_pkg::PH_WAIT, ure_pkg::PH_MEAS: begin
                if ((r_phase == ure_pkg::PH_MEAS) && fall) begin
                    o_raw.done  = 1'b1;
                    o_raw.pulse = pulse_sat;
                end else if (tout_hit) begin
                    o_raw.done      = 1'b1;
                    o_raw.timed_out = 1'b1;
                end
            end
            default: begin
                o_raw = '0;
            end
        endcase
        o_raw.busy = (n_phase != ure_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ure_pkg::PH_IDLE;
            r_pc        <= '0;
            r_since     <= '0;
            r_echo_prev <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_pc        <= n_pc;
            r_since     <= n_since;
            r_echo_prev <= i_echo;
        end
    end

endmodule

[sv/ure_queue.sv]
// Two-entry queue of raw results between the sequencer and the arithmetic.
// Depends on ure_pkg.
module ure_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ure_pkg::t_raw i_data,
    output logic          o_full,
    output logic          o_valid,
    output ure_pkg::t_raw o_data,
    input  logic          i_pop
);

    ure_pkg::t_raw r_mem [2];
    logic          r_wr, r_rd;
    logic [1:0]    r_count;
    logic          do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[sv/ure_back.sv]
// Result arithmetic: scale product, divide by 100 by reciprocal, range check.
// Two register stages, the second is the output register. Depends on ure_pkg.
module ure_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ure_pkg::t_raw i_raw,
    input  ure_pkg::t_cfg i_cfg,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [ure_pkg::OUT_TDATA_W-1:0] o_tdata
);

    logic                           r_v1, r_v2;
    ure_pkg::t_raw                  r_raw1, r_raw2;
    logic                           r_inr1, r_inr2;
    logic [ure_pkg::PROD_W-1:0]     r_prod1;
    logic [ure_pkg::MUL_W-1:0]      r_mul2;
    logic                           s2_ready, s1_ready;
    logic                           in_range;
    logic [ure_pkg::DIST_W-1:0]     dist_mm;

    assign s2_ready = !r_v2 || i_ready;
    assign s1_ready = !r_v1 || s2_ready;
    assign o_ready  = s1_ready;
    assign o_valid  = r_v2;

    // a zero pulse never passes the lower bound, so no gating on done
    assign in_range = (i_cfg.range_low < i_raw.pulse) && (i_raw.pulse < i_cfg.range_high);

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_raw1  <= i_raw;
            r_inr1  <= in_range;
            r_prod1 <= ure_pkg::PROD_W'(i_raw.pulse) * ure_pkg::PROD_W'(i_cfg.scale_mult);
        end
        if (s2_ready) begin
            r_raw2 <= r_raw1;
            r_inr2 <= r_inr1;
            r_mul2 <= ure_pkg::MUL_W'(r_prod1) * ure_pkg::MUL_W'(ure_pkg::RECIP_100);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= i_valid;
            end
            if (s2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    assign dist_mm = r_mul2[ure_pkg::RECIP_SHIFT +: ure_pkg::DIST_W];

    assign o_tdata = {1'b0, r_inr2, dist_mm, r_raw2.pulse, r_raw2.timed_out,
                      r_raw2.done, r_raw2.busy, r_raw2.trigger};

endmodule

[sv/ultrasonic_echo_ranger.sv]
// Ultrasonic echo ranger: one transfer in per tick (start request and echo
// level), one transfer out per tick carrying trigger level, busy, done,
// timeout flag, pulse width, distance in millimetres and an in-range flag.
// The block takes one tick every clock cycle while its queue is not full;
// the phase sequencer updates its phase, tick counters and echo history in
// the cycle a tick is accepted. The edge that accepts a tick also writes its
// raw result into the queue; from there it moves into the product stage and
// then into the output register, from which it transfers. A two-entry queue
// lets the input keep flowing while the output stalls, until the queue fills.
// Distance is pulse_ticks * scale_mult / 100, truncated, formed by a 16x8
// product followed by an exact reciprocal multiply. Registers sit on an APB
// port at byte addresses 0, 4, 8, 12 and 16; write them only while no
// measurement or result is in flight. Depends on ure_pkg, ure_front,
// ure_queue, ure_back and ultrasonic_echo_ranger_defines.svh.
`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tick stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] start_req, [1] echo, [7:2] zero
    input  logic [ure_pkg::IN_TDATA_W-1:0]    s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] trigger, [1] busy_res, [2] done_res, [3] timed_out,
    // [19:4] pulse_ticks, [37:20] distance_mm, [38] in_range, [39] zero
    output logic [ure_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ure_pkg::ADDR_W-1:0]        paddr,
    input  logic [ure_pkg::APB_W-1:0]         pwdata,
    output logic [ure_pkg::APB_W-1:0]         prdata,
    output logic                              pready
);

    ure_pkg::t_cfg  r_cfg;
    logic           cfg_wr;
    logic [2:0]     reg_idx;

    logic           q_full, q_valid, q_pop, f_push;
    ure_pkg::t_raw  f_raw, q_raw;

    logic           res_busy, res_done, res_tout, res_blank;
    logic           scale_wr;
    logic [ure_pkg::SCALE_W-1:0] scale_wdata;

    // ---------------------------------------------------------------
    // Configuration registers: written on the access phase of a transfer
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[ure_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks <= ure_pkg::TRIGGER_RST;
            r_cfg.timeout_ticks <= ure_pkg::TIMEOUT_RST;
            r_cfg.range_low     <= ure_pkg::RANGE_LOW_RST;
            r_cfg.range_high    <= ure_pkg::RANGE_HIGH_RST;
            r_cfg.scale_mult    <= ure_pkg::SCALE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                ure_pkg::REG_TRIGGER:    r_cfg.trigger_ticks <= pwdata[ure_pkg::TRIG_W-1:0];
                ure_pkg::REG_TIMEOUT:    r_cfg.timeout_ticks <= pwdata[ure_pkg::PULSE_W-1:0];
                ure_pkg::REG_RANGE_LOW:  r_cfg.range_low     <= pwdata[ure_pkg::PULSE_W-1:0];
                ure_pkg::REG_RANGE_HIGH: r_cfg.range_high    <= pwdata[ure_pkg::PULSE_W-1:0];
                ure_pkg::REG_SCALE:      r_cfg.scale_mult    <= pwdata[ure_pkg::SCALE_W-1:0];
                default: begin
                    // drop writes outside the register map
                end
            endcase
        end
    end

    // read back; addresses outside the map read as zero
    always_comb begin
        case (reg_idx)
            ure_pkg::REG_TRIGGER:    prdata = ure_pkg::APB_W'(r_cfg.trigger_ticks);
            ure_pkg::REG_TIMEOUT:    prdata = ure_pkg::APB_W'(r_cfg.timeout_ticks);
            ure_pkg::REG_RANGE_LOW:  prdata = ure_pkg::APB_W'(r_cfg.range_low);
            ure_pkg::REG_RANGE_HIGH: prdata = ure_pkg::APB_W'(r_cfg.range_high);
            ure_pkg::REG_SCALE:      prdata = ure_pkg::APB_W'(r_cfg.scale_mult);
            default:                 prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Front: phase sequencer, one tick per accepted transfer
    // ---------------------------------------------------------------
    ure_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_start (s_tdata[0]),
        .i_echo  (s_tdata[1]),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_push  (f_push),
        .o_raw   (f_raw)
    );

    // ---------------------------------------------------------------
    // Queue: hold raw results while the back end or the sink stalls
    // ---------------------------------------------------------------
    ure_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_raw),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_raw),
        .i_pop   (q_pop)
    );

    // ---------------------------------------------------------------
    // Back: distance and range arithmetic, output register
    // ---------------------------------------------------------------
    ure_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_pop),
        .i_raw   (q_raw),
        .i_cfg   (r_cfg),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_tdata (m_tdata)
    );

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    assign res_busy    = m_tdata[1];
    assign res_done    = m_tdata[2];
    assign res_tout    = m_tdata[3];
    assign res_blank   = (m_tdata[19:4] == '0) && (m_tdata[37:20] == '0) && !m_tdata[38];
    assign scale_wr    = cfg_wr && (reg_idx == ure_pkg::REG_SCALE);
    assign scale_wdata = pwdata[ure_pkg::SCALE_W-1:0];

    // a finished measurement always leaves the block idle
    `URE_ASSERT_NOW(a_done_not_busy, m_tvalid && res_done, !res_busy, "done while busy")
    // a timeout carries no width, distance or range result
    `URE_ASSERT_NOW(a_tout_empty, m_tvalid && res_tout, res_done && res_blank, "timeout with payload")
    // a scale write lands in the register on the next cycle
    `URE_ASSERT_NEXT(a_scale_write, scale_wr, r_cfg.scale_mult == $past(scale_wdata), "scale write lost")

endmodule

[test/ultrasonic_echo_ranger_tb.sv]
// Self-checking testbench for ultrasonic_echo_ranger: drives ticks and register
// writes, predicts every result with its own model of the ranger and checks it.
// Depends on ure_pkg and the ultrasonic_echo_ranger RTL only.
module ultrasonic_echo_ranger_tb;

    localparam int TRIG_W      = ure_pkg::TRIG_W;
    localparam int PULSE_W     = ure_pkg::PULSE_W;
    localparam int SCALE_W     = ure_pkg::SCALE_W;
    localparam int DIST_W      = ure_pkg::DIST_W;
    localparam int PROD_W      = ure_pkg::PROD_W;
    localparam int IN_TDATA_W  = ure_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = ure_pkg::OUT_TDATA_W;
    localparam int ADDR_W      = ure_pkg::ADDR_W;
    localparam int APB_W       = ure_pkg::APB_W;

    // no-progress limit: far above the longest stall or gap the stimulus makes
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    // pause after the last result before a register write or the end of run
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned RANDOM_TICKS   = 1000;
    localparam logic [PULSE_W-1:0] COUNT_MAX = '1;

    // one result transfer, last field in the lowest bits as on m_tdata
    typedef struct packed {
        logic               in_range;
        logic [DIST_W-1:0]  distance;
        logic [PULSE_W-1:0] pulse;
        logic               timed_out;
        logic               done;
        logic               busy;
        logic               trigger;
    } t_ranger_result;

    // one line of the directed script: a register write or a run of ticks
    typedef struct {
        bit                 write_row;
        ure_pkg::t_reg_idx  addr_idx;
        logic [31:0]        value;
        logic               start;
        logic               echo;
        int unsigned        reps;
        bit                 typed;
        t_ranger_result     want;
    } t_script_row;

    logic                   i_clk;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [ADDR_W-1:0]      paddr    = '0;
    logic [APB_W-1:0]       pwdata   = '0;
    logic [APB_W-1:0]       prdata;
    logic                   pready;

    // predictor copy of the registers and the sequencer state
    logic [TRIG_W-1:0]  cfg_trigger = ure_pkg::TRIGGER_RST;
    logic [PULSE_W-1:0] cfg_timeout = ure_pkg::TIMEOUT_RST;
    logic [PULSE_W-1:0] cfg_low     = ure_pkg::RANGE_LOW_RST;
    logic [PULSE_W-1:0] cfg_high    = ure_pkg::RANGE_HIGH_RST;
    logic [SCALE_W-1:0] cfg_scale   = ure_pkg::SCALE_RST;
    ure_pkg::t_phase    ph          = ure_pkg::PH_IDLE;
    logic [PULSE_W-1:0] ph_count    = '0;
    logic [PULSE_W-1:0] since_trig  = '0;
    logic               echo_last   = 1'b0;

    t_ranger_result pending_readings[$];
    t_script_row    script[$];

    bit          steady_flow  = 1'b1;
    int unsigned ticks_sent   = 0;
    int unsigned ready_hold   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned fail_count   = 0;
    int unsigned checked      = 0;
    int unsigned finished     = 0;
    int unsigned timeouts     = 0;
    int unsigned ranged       = 0;

    ultrasonic_echo_ranger #(
        .COUNT_WIDTH(16)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Ranger predictor
    // ------------------------------------------------------------------

    function automatic logic [PULSE_W-1:0] sat_inc(input logic [PULSE_W-1:0] v);
        return (v != COUNT_MAX) ? v + 1'b1 : v;
    endfunction

    // Advance the predicted sequencer by one tick and return that tick's result.
    function automatic t_ranger_result step_ranger(input logic start, input logic echo);
        t_ranger_result     r;
        logic [TRIG_W-1:0]  trig_len;
        logic               rise;
        logic               fall;
        logic [PROD_W-1:0]  product;
        r        = '0;
        trig_len = (cfg_trigger == '0) ? TRIG_W'(1) : cfg_trigger;
        rise     = echo & ~echo_last;
        fall     = ~echo & echo_last;
        case (ph)
            ure_pkg::PH_IDLE: begin
                // the accepting tick is already the first trigger tick
                if (start) begin
                    r.trigger  = 1'b1;
                    ph_count   = 16'd1;
                    since_trig = '0;
                    ph = (ph_count >= trig_len) ? ure_pkg::PH_WAIT : ure_pkg::PH_TRIG;
                end
            end
            ure_pkg::PH_TRIG: begin
                r.trigger = 1'b1;
                ph_count  = sat_inc(ph_count);
                if (ph_count >= trig_len || ph_count == COUNT_MAX) begin
                    ph         = ure_pkg::PH_WAIT;
                    since_trig = '0;
                end
            end
            default: begin
                since_trig = sat_inc(since_trig);
                // a falling edge beats a timeout landing on the same tick
                if (ph == ure_pkg::PH_MEAS && fall) begin
                    r.done     = 1'b1;
                    r.pulse    = ph_count;
                    product    = PROD_W'(ph_count) * PROD_W'(cfg_scale);
                    r.distance = DIST_W'(product / PROD_W'(100));
                    r.in_range = (cfg_low < ph_count) && (ph_count < cfg_high);
                    ph         = ure_pkg::PH_IDLE;
                    ph_count   = '0;
                end else if (since_trig >= cfg_timeout || since_trig == COUNT_MAX) begin
                    r.done      = 1'b1;
                    r.timed_out = 1'b1;
                    ph          = ure_pkg::PH_IDLE;
                    ph_count    = '0;
                end else if (ph == ure_pkg::PH_WAIT) begin
                    // echo already high when waiting began is not a rise
                    if (rise) begin
                        ph       = ure_pkg::PH_MEAS;
                        ph_count = 16'd1;
                    end
                end else begin
                    ph_count = sat_inc(ph_count);
                end
            end
        endcase
        echo_last = echo;
        r.busy    = (ph != ure_pkg::PH_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic t_ranger_result mk_result(input logic trig, input logic busy,
                                                 input logic done, input logic tout,
                                                 input int unsigned pulse,
                                                 input int unsigned dist_mm,
                                                 input logic inr);
        t_ranger_result r;
        r.trigger   = trig;
        r.busy      = busy;
        r.done      = done;
        r.timed_out = tout;
        r.pulse     = PULSE_W'(pulse);
        r.distance  = DIST_W'(dist_mm);
        r.in_range  = inr;
        return r;
    endfunction

    function automatic void add_ticks(input logic start, input logic echo,
                                      input int unsigned reps, input bit typed,
                                      input t_ranger_result want);
        t_script_row row;
        row.write_row = 1'b0;
        row.addr_idx  = ure_pkg::REG_TRIGGER;
        row.value     = '0;
        row.start     = start;
        row.echo      = echo;
        row.reps      = reps;
        row.typed     = typed;
        row.want      = want;
        script.push_back(row);
    endfunction

    function automatic void add_write(input ure_pkg::t_reg_idx idx, input logic [31:0] value);
        t_script_row row;
        row.write_row = 1'b1;
        row.addr_idx  = idx;
        row.value     = value;
        row.start     = 1'b0;
        row.echo      = 1'b0;
        row.reps      = 0;
        row.typed     = 1'b0;
        row.want      = '0;
        script.push_back(row);
    endfunction

    // Offer one tick, hold it until the transfer, then log its prediction.
    task automatic send_tick(input logic start, input logic echo);
        int unsigned gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-2){1'b0}}, echo, start};
        do @(posedge i_clk); while (!s_tready);
        pending_readings.push_back(step_ranger(start, echo));
        ticks_sent++;
    endtask

    // Drain every outstanding result, then let the pipeline empty out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup phase, access phase, then idle before the next transfer.
    task automatic write_reg(input ure_pkg::t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ure_pkg::REG_TRIGGER:    cfg_trigger = value[TRIG_W-1:0];
            ure_pkg::REG_TIMEOUT:    cfg_timeout = value[PULSE_W-1:0];
            ure_pkg::REG_RANGE_LOW:  cfg_low     = value[PULSE_W-1:0];
            ure_pkg::REG_RANGE_HIGH: cfg_high    = value[PULSE_W-1:0];
            ure_pkg::REG_SCALE:      cfg_scale   = value[SCALE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // One measurement: a few idle ticks, a start, then ticks until the ranger is
    // idle again. Mostly clean echo pulses of chosen width; some noisy echo and
    // some pulses that never fall, so the timeout ends them.
    task automatic run_measurement();
        int unsigned style;
        int unsigned lead;
        int unsigned waited;
        int          width;
        logic        echo;
        style  = $urandom_range(0, 99);
        lead   = $urandom_range(0, 5);
        waited = 0;
        case ($urandom_range(0, 6))
            0:       width = int'(cfg_low);
            1:       width = int'(cfg_low) + 1;
            2:       width = int'(cfg_high) - 1;
            3:       width = int'(cfg_high);
            4:       width = int'(cfg_high) + 1;
            default: width = $urandom_range(1, 60);
        endcase
        if (width < 1)
            width = 1;
        steady_flow = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'($urandom_range(0, 1)));
        send_tick(1'b1, (style < 85) ? 1'b0 : 1'($urandom_range(0, 1)));
        while (ph != ure_pkg::PH_IDLE) begin
            if (style >= 85) begin
                echo = 1'($urandom_range(0, 1));
            end else begin
                case (ph)
                    ure_pkg::PH_TRIG: echo = 1'b0;
                    ure_pkg::PH_WAIT: begin
                        echo = (waited >= lead);
                        waited++;
                    end
                    default: echo = (style >= 70) || (int'(ph_count) < width);
                endcase
            end
            // start during a measurement must be ignored
            send_tick(1'($urandom_range(0, 1)), echo);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [DIST_W-1:0] want,
                               input logic [DIST_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Random back-pressure on the result stream, with calm stretches.
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
            ready_hold <= pick_gap();
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_ranger_result got;
        t_ranger_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_ranger_result'(m_tdata[DIST_W+PULSE_W+4:0]);
            if (pending_readings.size() == 0) begin
                $error("result transfer with no tick outstanding: %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                check_field("trigger",     DIST_W'(want.trigger),   DIST_W'(got.trigger));
                check_field("busy_res",    DIST_W'(want.busy),      DIST_W'(got.busy));
                check_field("done_res",    DIST_W'(want.done),      DIST_W'(got.done));
                check_field("timed_out",   DIST_W'(want.timed_out), DIST_W'(got.timed_out));
                check_field("pulse_ticks", DIST_W'(want.pulse),     DIST_W'(got.pulse));
                check_field("distance_mm", want.distance,           got.distance);
                check_field("in_range",    DIST_W'(want.in_range),  DIST_W'(got.in_range));
                checked++;
                if (want.done && !want.timed_out)
                    finished++;
                if (want.timed_out)
                    timeouts++;
                if (want.in_range)
                    ranged++;
            end
        end
    end

    // Abort when no transfer of any kind has happened for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        int unsigned    random_base;
        int unsigned    sel;
        int unsigned    low_v;
        t_ranger_result idle_res;
        t_ranger_result trig_res;
        t_ranger_result tout_res;

        idle_res = mk_result(1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
        trig_res = mk_result(1'b1, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
        tout_res = mk_result(1'b0, 1'b0, 1'b1, 1'b1, 0, 0, 1'b0);

        // Reset values: idle output, echo ignored while idle
        add_ticks(1'b0, 1'b0, 3, 1'b1, idle_res);
        add_ticks(1'b0, 1'b1, 1, 1'b1, idle_res);
        // Start with echo already high; further starts while busy are ignored
        add_ticks(1'b1, 1'b1, 1, 1'b1, trig_res);
        add_ticks(1'b1, 1'b1, 9, 1'b1, trig_res);
        // Echo high as waiting begins is no rise; then a clean 20-tick pulse
        add_ticks(1'b0, 1'b1, 5, 1'b0, idle_res);
        add_ticks(1'b0, 1'b0, 3, 1'b0, idle_res);
        add_ticks(1'b0, 1'b1, 20, 1'b0, idle_res);
        add_ticks(1'b0, 1'b0, 1, 1'b1, mk_result(1'b0, 1'b0, 1'b1, 1'b0, 20, 3, 1'b0));
        // Zero trigger length acts as one tick; zero timeout fires at once
        add_write(ure_pkg::REG_TRIGGER, 32'd0);
        add_write(ure_pkg::REG_TIMEOUT, 32'd0);
        add_ticks(1'b1, 1'b0, 1, 1'b1, trig_res);
        add_ticks(1'b0, 1'b0, 1, 1'b1, tout_res);
        // Longer trigger, echo noise during it, then a plain timeout
        add_write(ure_pkg::REG_TIMEOUT, 32'd5);
        add_write(ure_pkg::REG_TRIGGER, 32'd16);
        add_ticks(1'b1, 1'b0, 1, 1'b1, trig_res);
        add_ticks(1'b1, 1'b1, 15, 1'b1, trig_res);
        add_ticks(1'b0, 1'b1, 5, 1'b1, tout_res);
        // Falling edge on the timeout tick wins
        add_write(ure_pkg::REG_TRIGGER, 32'd1);
        add_write(ure_pkg::REG_TIMEOUT, 32'd6);
        add_ticks(1'b1, 1'b0, 1, 1'b1, trig_res);
        add_ticks(1'b0, 1'b1, 5, 1'b0, idle_res);
        add_ticks(1'b0, 1'b0, 1, 1'b1, mk_result(1'b0, 1'b0, 1'b1, 1'b0, 5, 0, 1'b0));
        // Widest registers: full scale, widest window, longest timeout
        add_write(ure_pkg::REG_RANGE_LOW, 32'd0);
        add_write(ure_pkg::REG_RANGE_HIGH, 32'd65535);
        add_write(ure_pkg::REG_SCALE, 32'd255);
        add_write(ure_pkg::REG_TIMEOUT, 32'd65535);
        add_ticks(1'b1, 1'b0, 1, 1'b0, idle_res);
        add_ticks(1'b0, 1'b1, 400, 1'b0, idle_res);
        add_ticks(1'b0, 1'b0, 1, 1'b1, mk_result(1'b0, 1'b0, 1'b1, 1'b0, 400, 1020, 1'b1));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed script; typed rows replace the last prediction
        foreach (script[i]) begin
            steady_flow = ($urandom_range(0, 1) == 0);
            if (script[i].write_row) begin
                settle();
                write_reg(script[i].addr_idx, script[i].value);
            end else begin
                for (int unsigned n = 0; n < script[i].reps; n++)
                    send_tick(script[i].start, script[i].echo);
                if (script[i].typed)
                    pending_readings[pending_readings.size()-1] = script[i].want;
            end
        end

        // Random phases: fresh settings each time, small so pulses stay short
        random_base = ticks_sent;
        while (ticks_sent - random_base < RANDOM_TICKS) begin
            settle();
            sel   = $urandom_range(0, 7);
            low_v = $urandom_range(0, 40);
            write_reg(ure_pkg::REG_TRIGGER,
                      (sel == 0) ? 32'd0 : 32'($urandom_range(1, 6)));
            write_reg(ure_pkg::REG_TIMEOUT,
                      (sel == 1) ? 32'($urandom_range(0, 3)) : 32'($urandom_range(20, 110)));
            write_reg(ure_pkg::REG_RANGE_LOW, 32'(low_v));
            write_reg(ure_pkg::REG_RANGE_HIGH,
                      (sel == 2) ? 32'($urandom_range(0, low_v))
                                 : 32'(low_v + $urandom_range(1, 40)));
            write_reg(ure_pkg::REG_SCALE,
                      (sel == 3) ? 32'd0 : (sel == 4) ? 32'd255 : 32'($urandom_range(0, 255)));
            repeat (6) run_measurement();
        end

        settle();
        $display("Checked %0d result transfers from %0d ticks.", checked, ticks_sent);
        $display("Measurements: %0d echoes timed, %0d timeouts, %0d in range.",
                 finished, timeouts, ranged);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
